// ----- rtl/sdrs_pkg.sv -----
// ----------------------------------------------------------------------------
// sdrs_pkg
// Shared types and constants for the SCAN disk request scheduler.
// ----------------------------------------------------------------------------
package sdrs_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] WAIT_MAX  = 32'hFFFF_FFFF;
    localparam logic [47:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_SERVICE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic [1:0] REG_MAX_SECTOR      = 2'd0;
    localparam logic [1:0] REG_FIXED_COST      = 2'd1;
    localparam logic [1:0] REG_COST_PER_SECTOR = 2'd2;

    localparam logic [15:0] RST_MAX_SECTOR      = 16'd1024;
    localparam logic [15:0] RST_FIXED_COST      = 16'd2;
    localparam logic [7:0]  RST_COST_PER_SECTOR = 8'd1;

    typedef struct packed {
        logic        operation;
        logic [15:0] sector;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] served_sector;
        logic [31:0] served_wait;
        logic [23:0] seek_cost;
        logic [47:0] total_wait;
        logic        direction_up;
        logic [6:0]  occupancy;
    } t_out_word;

    typedef struct packed {
        logic [15:0] max_sector;
        logic [15:0] fixed_cost;
        logic [7:0]  cost_per_sector;
    } t_cfg;

endpackage

// ----- rtl/sdrs_cfg.sv -----
// ----------------------------------------------------------------------------
// sdrs_cfg
// APB register file holding the seek cost and sector range settings.
// ----------------------------------------------------------------------------
module sdrs_cfg
    import sdrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg        r_cfg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_sector      <= RST_MAX_SECTOR;
            r_cfg.fixed_cost      <= RST_FIXED_COST;
            r_cfg.cost_per_sector <= RST_COST_PER_SECTOR;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MAX_SECTOR:      r_cfg.max_sector      <= pwdata[15:0];
                REG_FIXED_COST:      r_cfg.fixed_cost      <= pwdata[15:0];
                REG_COST_PER_SECTOR: r_cfg.cost_per_sector <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MAX_SECTOR:      prdata = {16'd0, r_cfg.max_sector};
            REG_FIXED_COST:      prdata = {16'd0, r_cfg.fixed_cost};
            REG_COST_PER_SECTOR: prdata = {24'd0, r_cfg.cost_per_sector};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/scan_disk_request_scheduler.sv -----
// ----------------------------------------------------------------------------
// scan_disk_request_scheduler
// SCAN (elevator) scheduler over an ordered table of pending sector requests.
// ----------------------------------------------------------------------------
// Input words carry an operation (enqueue or service) and a sector. Each
// accepted word yields exactly one output word with status, served request,
// seek cost, running wait total, scan direction and occupancy.
// Enqueue and empty-service words go from idle straight to the finish state,
// which loads the output register. A service walks a table of N entries with
// one comparator: up to two passes of one entry per cycle, then the seek cost
// multiply, then the other waits are aged through one saturating adder, then
// the gap is closed, and the finish state loads the output. The finish state
// waits for a free output slot, and the next word is taken once the sequencer
// is back in idle.
// o_in_ready is high only while the sequencer is idle.
// The result sits in an output register; a stalled receiver holds it, and
// the next word may still be accepted, but its result waits for the slot.
// Reset (synchronous, active low) empties the table, parks the head at
// sector 0, sets the upward direction, clears the total and loads the
// register defaults. Registers are written over the APB port.
// ----------------------------------------------------------------------------
module scan_disk_request_scheduler
    import sdrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_COST   = 6'b000100,
        S_AGE    = 6'b001000,
        S_SHIFT  = 6'b010000,
        S_FIN    = 6'b100000
    } t_state;

    t_cfg        cfg;
    t_state      r_state, n_state;

    logic [15:0] r_sector [QUEUE_DEPTH];
    logic [31:0] r_wait   [QUEUE_DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [15:0] r_head;
    logic        r_scan_up;
    logic [47:0] r_total;

    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_pick;
    logic        r_found;
    logic [15:0] r_best;
    logic [1:0]  r_status;
    logic [15:0] r_srv_sector;
    logic [31:0] r_srv_wait;
    logic [23:0] r_cost;
    logic        r_out_valid;
    t_out_word   r_out;

    logic        in_acc;
    logic        out_free;
    logic [CNT_W-1:0] idx_next;
    logic [IDX_W-1:0] rd_addr;
    logic [15:0] rd_sector;
    logic [31:0] rd_wait;
    logic        last;
    logic        hit;
    logic [15:0] seek_dist;
    logic [23:0] cost_calc;
    logic [32:0] age_sum;
    logic [48:0] total_sum;
    logic        shift_more;

    sdrs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid & o_in_ready;
    assign out_free    = ~r_out_valid | i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign idx_next   = CNT_W'(r_idx) + CNT_W'(1);
    assign rd_addr    = (r_state == S_SHIFT) ? idx_next[IDX_W-1:0] : r_idx;
    assign rd_sector  = r_sector[rd_addr];
    assign rd_wait    = r_wait[rd_addr];
    assign last       = (idx_next == r_count);
    assign shift_more = (idx_next < r_count);

    always_comb begin
        if (r_scan_up) begin
            hit = (rd_sector >= r_head) && (!r_found || rd_sector <= r_best);
        end else begin
            hit = (rd_sector <= r_head) && (!r_found || rd_sector >= r_best);
        end
    end

    assign seek_dist = (r_best >= r_head) ? (r_best - r_head) : (r_head - r_best);
    assign cost_calc = 24'(cfg.fixed_cost) + 24'(cfg.cost_per_sector) * 24'(seek_dist);
    assign age_sum   = 33'(rd_wait) + 33'(r_cost);
    assign total_sum = 49'(r_total) + 49'(r_srv_wait);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.operation == OP_SERVICE && r_count != '0) begin
                        n_state = S_SEARCH;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SEARCH: begin
                if (last && (r_found || hit)) begin
                    n_state = S_COST;
                end
            end
            S_COST:  n_state = S_AGE;
            S_AGE: begin
                if (last) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (!shift_more) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // table storage, no reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_data.operation == OP_ENQUEUE &&
                    i_in_data.sector <= cfg.max_sector &&
                    r_count < CNT_W'(QUEUE_DEPTH)) begin
                    r_sector[r_count[IDX_W-1:0]] <= i_in_data.sector;
                    r_wait[r_count[IDX_W-1:0]]   <= 32'd0;
                end
            end
            S_AGE: begin
                if (r_idx != r_pick) begin
                    r_wait[r_idx] <= age_sum[32] ? WAIT_MAX : age_sum[31:0];
                end
            end
            S_SHIFT: begin
                if (shift_more) begin
                    r_sector[r_idx] <= rd_sector;
                    r_wait[r_idx]   <= rd_wait;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= 16'd0;
            r_scan_up   <= 1'b1;
            r_total     <= 48'd0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_found     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    if (in_acc && i_in_data.operation == OP_ENQUEUE &&
                        i_in_data.sector <= cfg.max_sector &&
                        r_count < CNT_W'(QUEUE_DEPTH)) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                S_SEARCH: begin
                    if (hit) begin
                        r_found <= 1'b1;
                    end
                    if (last) begin
                        r_idx <= '0;
                        if (!(r_found || hit)) begin
                            r_scan_up <= ~r_scan_up;
                        end
                    end else begin
                        r_idx <= idx_next[IDX_W-1:0];
                    end
                end
                S_COST: begin
                    r_head  <= r_best;
                    r_total <= total_sum[48] ? TOTAL_MAX : total_sum[47:0];
                end
                S_AGE: begin
                    r_idx <= last ? r_pick : idx_next[IDX_W-1:0];
                end
                S_SHIFT: begin
                    if (shift_more) begin
                        r_idx <= idx_next[IDX_W-1:0];
                    end else begin
                        r_count <= r_count - CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath holding registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_srv_sector <= 16'd0;
                    r_srv_wait   <= 32'd0;
                    r_cost       <= 24'd0;
                    if (i_in_data.operation == OP_ENQUEUE) begin
                        if (i_in_data.sector > cfg.max_sector) begin
                            r_status <= ST_RANGE;
                        end else if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_status <= ST_OK;
                        end
                    end else if (r_count == '0) begin
                        r_status <= ST_EMPTY;
                    end else begin
                        r_status <= ST_OK;
                    end
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    r_best     <= rd_sector;
                    r_pick     <= r_idx;
                    r_srv_wait <= rd_wait;
                end
                if (last && (r_found || hit)) begin
                    r_srv_sector <= hit ? rd_sector : r_best;
                end
            end
            S_COST: begin
                r_cost <= cost_calc;
            end
            S_FIN: begin
                if (out_free) begin
                    r_out.status        <= r_status;
                    r_out.served_sector <= r_srv_sector;
                    r_out.served_wait   <= r_srv_wait;
                    r_out.seek_cost     <= r_cost;
                    r_out.total_wait    <= r_total;
                    r_out.direction_up  <= r_scan_up;
                    r_out.occupancy     <= 7'(r_count);
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- test/tb_scan_disk_request_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scan_disk_request_scheduler
// Self-checking testbench for the SCAN disk request scheduler.
// ----------------------------------------------------------------------------
// Enqueue and service words are driven on the input channel while both sides
// idle in random bursts. A local elevator model predicts every output word,
// and the checker compares each field against the oldest prediction.
// Registers are rewritten over APB between phases, covering the range limit,
// seek cost extremes, full queue, empty service, ties and stale entries.
// ----------------------------------------------------------------------------
module tb_scan_disk_request_scheduler;
    import sdrs_pkg::*;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_word    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b1;
    t_out_word   o_out_data;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    scan_disk_request_scheduler u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // elevator model state
    logic [15:0] q_sector [QUEUE_DEPTH];
    logic [31:0] q_wait   [QUEUE_DEPTH];
    int          q_count      = 0;
    logic [15:0] head_pos     = '0;
    logic        sweep_up     = 1'b1;
    logic [47:0] served_total = '0;
    t_cfg        cfg_model    = '{RST_MAX_SECTOR, RST_FIXED_COST, RST_COST_PER_SECTOR};

    t_out_word   expected_words[$];
    t_out_word   want_word;
    int          mismatch_count = 0;
    int          word_index     = 0;
    logic [15:0] last_sector    = '0;
    bit          tx_idling      = 1'b1;
    bit          rx_idling      = 1'b1;
    int          stall_left     = 0;

    function automatic int nearest_pending(logic up);
        int          pick;
        logic [15:0] best;
        logic [15:0] s;
        bit          ok;
        pick = -1;
        best = '0;
        for (int i = 0; i < q_count; i++) begin
            s = q_sector[i];
            if (up) begin
                ok = (s >= head_pos) && (pick < 0 || s <= best);
            end else begin
                ok = (s <= head_pos) && (pick < 0 || s >= best);
            end
            if (ok) begin
                best = s;
                pick = i;
            end
        end
        return pick;
    endfunction

    function automatic t_out_word scan_step(t_in_word w);
        t_out_word   r;
        int          p;
        logic [15:0] seek_dist;
        logic [23:0] cost;
        logic [32:0] aged;
        logic [48:0] sum;
        r = '0;
        r.status = ST_OK;
        if (w.operation == OP_ENQUEUE) begin
            if (w.sector > cfg_model.max_sector) begin
                r.status = ST_RANGE;
            end else if (q_count >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                q_sector[q_count] = w.sector;
                q_wait[q_count]   = '0;
                q_count++;
            end
        end else if (q_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            p = nearest_pending(sweep_up);
            if (p < 0) begin
                sweep_up = ~sweep_up;
                p = nearest_pending(sweep_up);
            end
            r.served_sector = q_sector[p];
            r.served_wait   = q_wait[p];
            seek_dist = (q_sector[p] >= head_pos) ? q_sector[p] - head_pos
                                                  : head_pos - q_sector[p];
            cost = 24'(cfg_model.fixed_cost) + 24'(cfg_model.cost_per_sector) * 24'(seek_dist);
            r.seek_cost = cost;
            for (int i = 0; i < q_count; i++) begin
                if (i != p) begin
                    aged = {1'b0, q_wait[i]} + 33'(cost);
                    q_wait[i] = aged[32] ? WAIT_MAX : aged[31:0];
                end
            end
            sum = {1'b0, served_total} + 49'(r.served_wait);
            served_total = sum[48] ? TOTAL_MAX : sum[47:0];
            head_pos = r.served_sector;
            for (int i = p; i + 1 < q_count; i++) begin
                q_sector[i] = q_sector[i + 1];
                q_wait[i]   = q_wait[i + 1];
            end
            q_count--;
        end
        r.total_wait   = served_total;
        r.direction_up = sweep_up;
        r.occupancy    = 7'(q_count);
        return r;
    endfunction

    function automatic logic [15:0] pick_sector();
        case ($urandom_range(0, 11))
            0:       return head_pos;
            1:       return cfg_model.max_sector;
            2:       return 16'd0;
            3:       return last_sector;
            4:       return 16'($urandom);
            5:       return head_pos + 16'd1;
            default: return 16'($urandom_range(0, cfg_model.max_sector));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t: word %0d: %s", $time, word_index, msg);
    endtask

    task automatic check_field(input string name, input logic [47:0] got,
                               input logic [47:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("output word with nothing pending");
            end else begin
                want_word = expected_words.pop_front();
                check_field("status", 48'(o_out_data.status), 48'(want_word.status));
                check_field("served_sector", 48'(o_out_data.served_sector),
                            48'(want_word.served_sector));
                check_field("served_wait", 48'(o_out_data.served_wait),
                            48'(want_word.served_wait));
                check_field("seek_cost", 48'(o_out_data.seek_cost),
                            48'(want_word.seek_cost));
                check_field("total_wait", o_out_data.total_wait, want_word.total_wait);
                check_field("direction_up", 48'(o_out_data.direction_up),
                            48'(want_word.direction_up));
                check_field("occupancy", 48'(o_out_data.occupancy),
                            48'(want_word.occupancy));
            end
            word_index++;
        end
    end

    // receiver stalls
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_left != 0) begin
                stall_left--;
                if (stall_left == 0) begin
                    i_out_ready <= 1'b1;
                end
            end else if (rx_idling && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(1, 17);
            end
        end
    end

    task automatic issue_request(input logic op, input logic [15:0] sector);
        t_in_word w;
        int       gap;
        w.operation = op;
        w.sector    = sector;
        if (tx_idling && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        expected_words = {expected_words, scan_step(w)};
        last_sector = sector;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        mask = (idx == REG_COST_PER_SECTOR) ? 32'h0000_00FF : 32'h0000_FFFF;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_MAX_SECTOR:      cfg_model.max_sector      = value[15:0];
            REG_FIXED_COST:      cfg_model.fixed_cost      = value[15:0];
            REG_COST_PER_SECTOR: cfg_model.cost_per_sector = value[7:0];
            default: ;
        endcase
        // read back
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if ((prdata & mask) !== (value & mask)) begin
            report_mismatch($sformatf("register %0d read %0h want %0h",
                                      idx, prdata & mask, value & mask));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [15:0] max_sec, input logic [15:0] fixed,
                                  input logic [7:0] per_sec);
        settle();
        write_register(REG_MAX_SECTOR, 32'(max_sec));
        write_register(REG_FIXED_COST, 32'(fixed));
        write_register(REG_COST_PER_SECTOR, 32'(per_sec));
    endtask

    task automatic drive_sweeps(input int n_items);
        int sent;
        int k;
        int m;
        sent = 0;
        while (sent < n_items) begin
            k = $urandom_range(1, QUEUE_DEPTH + 1);
            repeat (k) begin
                issue_request(OP_ENQUEUE, pick_sector());
                sent++;
            end
            m = $urandom_range(1, k + 1);
            repeat (m) begin
                issue_request(OP_SERVICE, 16'($urandom));
                sent++;
            end
        end
    endtask

    task automatic drive_noise(input int n_items);
        repeat (n_items) begin
            issue_request(1'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_empty_and_range();
        issue_request(OP_SERVICE, 16'hFFFF);
        issue_request(OP_ENQUEUE, 16'd0);
        issue_request(OP_ENQUEUE, 16'd1024);
        issue_request(OP_ENQUEUE, 16'd1025);
        issue_request(OP_ENQUEUE, 16'hFFFF);
    endtask

    task automatic test_full_and_precedence();
        issue_request(OP_ENQUEUE, 16'd500);
        issue_request(OP_ENQUEUE, 16'd500);
        issue_request(OP_ENQUEUE, 16'd300);
        issue_request(OP_ENQUEUE, 16'd700);
        issue_request(OP_ENQUEUE, 16'd300);
        issue_request(OP_ENQUEUE, 16'd100);
        issue_request(OP_ENQUEUE, 16'd200);
        issue_request(OP_ENQUEUE, 16'd2000);
    endtask

    task automatic test_stale_and_cost_extremes();
        settle();
        write_register(REG_MAX_SECTOR, 32'd0);
        issue_request(OP_ENQUEUE, 16'd0);
        issue_request(OP_ENQUEUE, 16'd1);
        repeat (4) issue_request(OP_SERVICE, 16'd0);
        settle();
        write_register(REG_FIXED_COST, 32'hFFFF);
        write_register(REG_COST_PER_SECTOR, 32'hFF);
        repeat (2) issue_request(OP_SERVICE, 16'd0);
        settle();
        write_register(REG_MAX_SECTOR, 32'hFFFF);
        issue_request(OP_ENQUEUE, 16'hFFFF);
        settle();
        write_register(REG_FIXED_COST, 32'd0);
        write_register(REG_COST_PER_SECTOR, 32'd0);
        repeat (3) issue_request(OP_SERVICE, 16'd0);
    endtask

    task automatic test_random_sweeps();
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: apply_settings(RST_MAX_SECTOR, RST_FIXED_COST, RST_COST_PER_SECTOR);
                1: apply_settings(16'hFFFF, 16'hFFFF, 8'hFF);
                2: apply_settings(16'd15, 16'd0, 8'd0);
                3: apply_settings(16'd300, 16'd7, 8'd3);
                default: apply_settings(16'($urandom_range(1, 65535)), 16'($urandom),
                                        8'($urandom));
            endcase
            tx_idling = ($urandom_range(0, 3) != 0);
            rx_idling = ($urandom_range(0, 3) != 0);
            drive_sweeps(300);
        end
    endtask

    task automatic test_random_noise();
        apply_settings(16'($urandom_range(1, 65535)), 16'($urandom), 8'($urandom));
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        drive_noise(250);
    endtask

    task automatic test_quiet_tail();
        apply_settings(16'hFFFF, 16'($urandom), 8'($urandom));
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        drive_sweeps(200);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_and_range();
        test_full_and_precedence();
        test_stale_and_cost_extremes();
        test_random_sweeps();
        test_random_noise();
        test_quiet_tail();
        settle();
        repeat (40) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            report_mismatch("words still pending at end of run");
        end
        if (mismatch_count == 0) begin
            $display("[scan_disk_request_scheduler] OK");
        end else begin
            $display("[scan_disk_request_scheduler] ERROR");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("[scan_disk_request_scheduler] ERROR");
        $finish;
    end

endmodule
